// ----- hdl/tmd5_pkg.sv -----
package tmd5_pkg;

  localparam int PACKET_BYTES = 2048;
  localparam int KEY_BYTES = 16;
  localparam int PKT_AW = $clog2(PACKET_BYTES);
  localparam int CNT_W = PKT_AW + 1;
  localparam logic [7:0] TCP_PROTO_NUM = 8'd6;

  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    S_IDLE, S_PRE_RD, S_PRE_FEED, S_PRE_CMP, S_TR_FEED, S_TR_CMP, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_ADDR, PH_PSEUDO, PH_TCP, PH_DATA, PH_KEY, PH_ZERO, PH_LEN
  } phase_t;

endpackage

// ----- hdl/tmd5_round_unit.sv -----
module tmd5_round_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] w_in [4],
  input  logic [31:0] m_word,
  output logic [3:0]  g_idx,
  output logic        done,
  output logic [31:0] w_out [4]
);
  import tmd5_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] base_r [4];
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] f, x, rot;
  logic [63:0] rot_wide;
  logic [4:0]  sh;

  always_comb begin
    case (rnd_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g_idx = rnd_r[3:0];
      end
      2'd1: begin
        f = (d_r & b_r) | (~d_r & c_r);
        g_idx = rnd_r[3:0] * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g_idx = rnd_r[3:0] * 4'd3 + 4'd5;
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g_idx = rnd_r[3:0] * 4'd7;
      end
    endcase
    sh = MD5_S[{rnd_r[5:4], rnd_r[1:0]}];
    x = a_r + f + MD5_K[rnd_r] + m_word;
    rot_wide = {x, x} << sh;
    rot = rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      done_r <= busy_r && (rnd_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        rnd_r <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= w_in[0];
      b_r <= w_in[1];
      c_r <= w_in[2];
      d_r <= w_in[3];
      base_r <= w_in;
    end else if (busy_r) begin
      a_r <= d_r;
      b_r <= b_r + rot;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  assign done = done_r;
  assign w_out[0] = base_r[0] + a_r;
  assign w_out[1] = base_r[1] + b_r;
  assign w_out[2] = base_r[2] + c_r;
  assign w_out[3] = base_r[3] + d_r;

endmodule

// ----- hdl/tcp_md5_signature_key_trial_core.sv -----
// packet byte words: accepted while the core is idle, no result
// last packet byte: prefix hash reads and feeds each prefix byte, compresses each full 64-byte block
// key trial: key, padding and length bytes follow the prefix midstate; each full block is
//   compressed by the single md5 round unit doing one round per cycle before the result
// trial with no packet loaded: zero digest, trial status set, no hashing; next word after result
// sync active-low reset clears control, midstate valid flag and target registers
module tcp_md5_signature_key_trial_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_packet_last,
  input  logic [63:0] in_key_bytes_low,
  input  logic [63:0] in_key_bytes_high,
  input  logic [4:0]  in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_key_matches,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high,
  output logic        out_trial_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tmd5_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [63:0] tgt_lo_r, tgt_hi_r;
  logic [7:0]  pkt_mem [PACKET_BYTES];
  logic [7:0]  mem_q_r;
  logic [CNT_W-1:0] count_r, count_nxt, n_r, pos_r;
  logic [6:0]  head_r;
  logic [31:0] work_w_r [4];
  logic [31:0] mid_w_r [4];
  logic [31:0] blk_r [16];
  logic [31:0] mid_blk_r [16];
  logic [15:0] total_r, prefix_len_r, seg;
  logic        prefix_ready_r;
  logic [127:0] key_r;
  logic [4:0]  klen_r, cnt_r;
  logic [18:0] len_bits_r;
  logic        final_r;
  logic        out_valid_r, out_match_r, out_status_r;
  logic [63:0] out_lo_r, out_hi_r;

  logic        feed_en, cmp_start, pre_done, blk_full, slot_free, cfg_wr;
  logic [7:0]  feed_byte, pre_byte, tr_byte, len_byte, pkt_q;
  logic [3:0]  core_g;
  logic        core_done;
  logic [31:0] core_w [4];
  logic [63:0] dig_lo, dig_hi;

  tmd5_round_unit u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_start),
    .w_in   (work_w_r),
    .m_word (blk_r[core_g]),
    .g_idx  (core_g),
    .done   (core_done),
    .w_out  (core_w)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? tgt_hi_r : tgt_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_lo_r <= '0;
      tgt_hi_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) tgt_hi_r <= pwdata;
      else tgt_lo_r <= pwdata;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign count_nxt = (count_r < CNT_W'(PACKET_BYTES)) ? count_r + CNT_W'(1) : count_r;
  assign blk_full = (total_r[5:0] == 6'd63);
  assign pre_done = (phase_r == PH_DATA) && (pos_r >= n_r);
  assign seg = 16'(n_r) - 16'd20;
  assign pkt_q = (pos_r < n_r) ? mem_q_r : 8'd0;

  always_comb begin
    case (phase_r)
      PH_ADDR: pre_byte = pkt_q;
      PH_PSEUDO: begin
        case (pos_r[1:0])
          2'd0: pre_byte = 8'd0;
          2'd1: pre_byte = TCP_PROTO_NUM;
          2'd2: pre_byte = seg[15:8];
          default: pre_byte = seg[7:0];
        endcase
      end
      // checksum bytes are hashed as zero
      PH_TCP: pre_byte = (pos_r == CNT_W'(36) || pos_r == CNT_W'(37)) ? 8'd0 : pkt_q;
      default: pre_byte = pkt_q;
    endcase
  end

  always_comb begin
    case (cnt_r[2:0])
      3'd0: len_byte = len_bits_r[7:0];
      3'd1: len_byte = len_bits_r[15:8];
      3'd2: len_byte = {5'd0, len_bits_r[18:16]};
      default: len_byte = 8'd0;
    endcase
    case (phase_r)
      PH_KEY: tr_byte = (cnt_r < klen_r) ? key_r[{cnt_r[3:0], 3'b000} +: 8] : 8'h80;
      PH_ZERO: tr_byte = (total_r[5:0] == 6'd56) ? len_bits_r[7:0] : 8'd0;
      default: tr_byte = len_byte;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    feed_en = 1'b0;
    feed_byte = tr_byte;
    cmp_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            if (in_packet_last) state_nxt = S_PRE_RD;
          end else if (prefix_ready_r) begin
            state_nxt = S_TR_FEED;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_PRE_RD: state_nxt = pre_done ? S_IDLE : S_PRE_FEED;
      S_PRE_FEED: begin
        feed_en = 1'b1;
        feed_byte = pre_byte;
        if (blk_full) begin
          cmp_start = 1'b1;
          state_nxt = S_PRE_CMP;
        end else begin
          state_nxt = S_PRE_RD;
        end
      end
      S_PRE_CMP: if (core_done) state_nxt = S_PRE_RD;
      S_TR_FEED: begin
        feed_en = 1'b1;
        if (blk_full) begin
          cmp_start = 1'b1;
          state_nxt = S_TR_CMP;
        end
      end
      S_TR_CMP: if (core_done) state_nxt = final_r ? S_OUT : S_TR_FEED;
      S_OUT: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // packet store
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_mode && count_r < CNT_W'(PACKET_BYTES))
      pkt_mem[count_r[PKT_AW-1:0]] <= in_packet_byte;
    mem_q_r <= pkt_mem[pos_r[PKT_AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prefix_ready_r <= 1'b0;
      prefix_len_r <= '0;
      mid_w_r <= MD5_IV;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && slot_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_IDLE && in_valid && !in_mode)
        count_r <= in_packet_last ? '0 : count_nxt;
      if (state_r == S_PRE_RD && pre_done) begin
        prefix_ready_r <= 1'b1;
        prefix_len_r <= total_r;
        mid_w_r <= work_w_r;
      end
    end
  end

  assign dig_lo = {work_w_r[1], work_w_r[0]};
  assign dig_hi = {work_w_r[3], work_w_r[2]};

  // hash datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      if (!in_mode) begin
        n_r <= count_nxt;
        phase_r <= PH_ADDR;
        pos_r <= CNT_W'(12);
        work_w_r <= MD5_IV;
        total_r <= '0;
      end else begin
        work_w_r <= mid_w_r;
        blk_r <= mid_blk_r;
        total_r <= prefix_len_r;
        key_r <= {in_key_bytes_high, in_key_bytes_low};
        klen_r <= (in_key_length > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : in_key_length;
        cnt_r <= '0;
        phase_r <= PH_KEY;
        final_r <= 1'b0;
      end
    end
    if (feed_en) begin
      blk_r[total_r[5:2]][{total_r[1:0], 3'b000} +: 8] <= feed_byte;
      total_r <= total_r + 16'd1;
    end
    if (core_done) work_w_r <= core_w;
    if (state_r == S_PRE_RD && pre_done) mid_blk_r <= blk_r;

    if (state_r == S_PRE_FEED) begin
      case (phase_r)
        PH_ADDR: begin
          if (pos_r == CNT_W'(19)) begin
            phase_r <= PH_PSEUDO;
            pos_r <= '0;
          end else begin
            pos_r <= pos_r + CNT_W'(1);
          end
        end
        PH_PSEUDO: begin
          if (pos_r == CNT_W'(3)) begin
            phase_r <= PH_TCP;
            pos_r <= CNT_W'(20);
          end else begin
            pos_r <= pos_r + CNT_W'(1);
          end
        end
        PH_TCP: begin
          // data offset byte gives where the payload starts
          if (pos_r == CNT_W'(32)) head_r <= 7'd20 + {1'b0, pre_byte[7:4], 2'b00};
          if (pos_r == CNT_W'(39)) begin
            phase_r <= PH_DATA;
            pos_r <= CNT_W'(head_r);
          end else begin
            pos_r <= pos_r + CNT_W'(1);
          end
        end
        default: pos_r <= pos_r + CNT_W'(1);
      endcase
    end

    if (state_r == S_TR_FEED) begin
      case (phase_r)
        PH_KEY: begin
          if (cnt_r < klen_r) begin
            cnt_r <= cnt_r + 5'd1;
          end else begin
            len_bits_r <= {total_r, 3'b000};
            phase_r <= PH_ZERO;
          end
        end
        PH_ZERO: begin
          if (total_r[5:0] == 6'd56) begin
            phase_r <= PH_LEN;
            cnt_r <= 5'd1;
          end
        end
        default: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r[2:0] == 3'd7) final_r <= 1'b1;
        end
      endcase
    end

    if (state_r == S_OUT && slot_free) begin
      if (prefix_ready_r) begin
        out_lo_r <= dig_lo;
        out_hi_r <= dig_hi;
        out_match_r <= (dig_lo == tgt_lo_r) && (dig_hi == tgt_hi_r);
        out_status_r <= 1'b0;
      end else begin
        out_lo_r <= '0;
        out_hi_r <= '0;
        out_match_r <= 1'b0;
        out_status_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_key_matches = out_match_r;
  assign out_digest_low = out_lo_r;
  assign out_digest_high = out_hi_r;
  assign out_trial_status = out_status_r;

endmodule
